[src/mbps_pkg.sv]
// Package for the masked byte pattern scan block.
// Holds the configuration register indexes, field widths, reset values and the result beat type.
// No dependencies.
package mbps_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_PATTERN_LOW  = 3'd0;
    localparam cfg_idx_t CFG_PATTERN_HIGH = 3'd1;
    localparam cfg_idx_t CFG_CARE_MASK    = 3'd2;
    localparam cfg_idx_t CFG_PATTERN_LEN  = 3'd3;
    localparam cfg_idx_t CFG_SCAN_STRIDE  = 3'd4;
    localparam cfg_idx_t CFG_REGION_BASE  = 3'd5;

    // Field widths fixed by the interface
    localparam int unsigned DATA_W = 64;
    localparam int unsigned LEN_W  = 5;
    localparam int unsigned POS_W  = 32;

    // Reset values of the configuration registers
    localparam logic [15:0]      CARE_MASK_RST = 16'hFFFF;
    localparam logic [LEN_W-1:0] PATTERN_LEN_RST = 5'd1;
    localparam logic [15:0]      SCAN_STRIDE_RST = 16'd1;

    // One result beat
    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] address;
    } result_t;

endpackage

[src/masked_byte_pattern_scan_top.sv]
// Masked byte pattern scan, top level.
// Depends on mbps_pkg for register indexes, widths and the result beat type.
// Sustained rate is one byte per cycle while in_stall is low: the window shift,
// the masked compare of up to PATTERN_MAX bytes and the 64-bit address add all
// sit between the window registers and the output register, so each byte is
// finished in the cycle it is accepted and its result, if any, is registered.
// A byte yields a result only on the first match in a region (match_found 1,
// match_address = region_base + start offset) or on the last byte of a region
// with no match (match_found 0, match_address 0). A second output stage
// lets one result wait while the next byte is taken; in_stall rises only when
// both output stages are full. Configuration writes take effect from the next
// byte on.
module masked_byte_pattern_scan_top
#(
    parameter int unsigned PATTERN_MAX = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Byte stream in
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       region_end,
    // Result out
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       match_found,
    output logic [mbps_pkg::DATA_W-1:0] match_address,
    // Configuration write port
    input  logic                       cfg_write,
    input  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbps_pkg::DATA_W-1:0] cfg_data
);
    import mbps_pkg::*;

    localparam int unsigned DEPTH = PATTERN_MAX;
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers
    logic [DATA_W-1:0] pattern_low_reg;
    logic [DATA_W-1:0] pattern_high_reg;
    logic [15:0]       care_mask_reg;
    logic [LEN_W-1:0]  pattern_length_reg;
    logic [15:0]       scan_stride_reg;
    logic [DATA_W-1:0] region_base_reg;

    // Scan state
    logic [7:0]        window_reg [DEPTH];
    logic [7:0]        window_next [DEPTH];
    logic [DEPTH-1:0]  flags_reg;
    logic [DEPTH-1:0]  flags_next;
    logic [15:0]       phase_reg;
    logic [15:0]       phase_next;
    logic [POS_W-1:0]  position_reg;
    logic              matched_reg;

    // Output stages
    result_t           out_reg;
    logic              out_valid_reg;
    result_t           skid_reg;
    logic              skid_valid_reg;

    logic              in_fire;
    logic              out_fire;
    logic [2*DATA_W-1:0] pattern_all;
    logic [LEN_W-1:0]  len_used;
    logic [IDX_W-1:0]  last_idx;
    logic [16:0]       stride_eff;
    logic [16:0]       phase_inc;
    logic [DEPTH-1:0]  byte_ok;
    logic              hit;
    logic              produce;
    logic [POS_W-1:0]  start_offset;
    result_t           result_new;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    assign out_valid     = out_valid_reg;
    assign match_found   = out_reg.found;
    assign match_address = out_reg.address;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= CARE_MASK_RST;
            pattern_length_reg <= PATTERN_LEN_RST;
            scan_stride_reg    <= SCAN_STRIDE_RST;
            region_base_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                CFG_CARE_MASK:    care_mask_reg      <= cfg_data[15:0];
                CFG_PATTERN_LEN:  pattern_length_reg <= cfg_data[LEN_W-1:0];
                CFG_SCAN_STRIDE:  scan_stride_reg    <= cfg_data[15:0];
                CFG_REGION_BASE:  region_base_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Clamp the pattern length to 1..PATTERN_MAX
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_used = LEN_W'(1);
        end
        else if (pattern_length_reg > LEN_W'(DEPTH))
        begin
            len_used = LEN_W'(DEPTH);
        end
        else
        begin
            len_used = pattern_length_reg;
        end
    end

    assign last_idx    = IDX_W'(len_used - LEN_W'(1));
    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    // Shift the new byte into the window and its start flag alongside
    always_comb
    begin
        window_next[0] = data_byte;
        flags_next[0]  = (phase_reg == '0);
        for (int k = 1; k < DEPTH; k++)
        begin
            window_next[k] = window_reg[k-1];
            flags_next[k]  = flags_reg[k-1];
        end
    end

    // Advance the stride phase, a zero stride acting as one
    assign stride_eff = (scan_stride_reg == '0) ? 17'd1 : {1'b0, scan_stride_reg};
    assign phase_inc  = {1'b0, phase_reg} + 17'd1;
    assign phase_next = (phase_inc >= stride_eff) ? 16'd0 : phase_inc[15:0];

    // Masked compare: pattern byte j against the byte (len-1-j) steps old
    always_comb
    begin
        logic [LEN_W-1:0] age;
        for (int j = 0; j < DEPTH; j++)
        begin
            age = LEN_W'(len_used - LEN_W'(1) - LEN_W'(j));
            if ((LEN_W'(j) >= len_used) || !care_mask_reg[j])
            begin
                byte_ok[j] = 1'b1;
            end
            else
            begin
                byte_ok[j] = (pattern_all[8*j +: 8] == window_next[age[IDX_W-1:0]]);
            end
        end
    end

    assign hit          = !matched_reg && flags_next[last_idx] && (&byte_ok);
    assign produce      = hit || (region_end && !matched_reg);
    assign start_offset = position_reg - POS_W'(last_idx);

    always_comb
    begin
        result_new.found   = hit;
        result_new.address = hit ? (region_base_reg + {{(DATA_W-POS_W){1'b0}}, start_offset})
                                 : '0;
    end

    // Hold the window bytes; no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                window_reg[k] <= window_next[k];
            end
        end
    end

    // Advance scan state, drop it at the end of a region
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg    <= '0;
            phase_reg    <= '0;
            position_reg <= '0;
            matched_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            if (region_end)
            begin
                flags_reg    <= '0;
                phase_reg    <= '0;
                position_reg <= '0;
                matched_reg  <= 1'b0;
            end
            else
            begin
                flags_reg    <= flags_next;
                phase_reg    <= phase_next;
                position_reg <= position_reg + POS_W'(1);
                matched_reg  <= matched_reg || hit;
            end
        end
    end

    // Output stage: refill from the skid stage first, else from a new beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_fire || !out_valid_reg)
            begin
                out_valid_reg  <= skid_valid_reg || (in_fire && produce);
                skid_valid_reg <= 1'b0;
            end
            else if (in_fire && produce)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !out_valid_reg)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result_new;
        end
        else if (in_fire && produce && !skid_valid_reg)
        begin
            skid_reg <= result_new;
        end
    end

`ifndef SYNTHESIS
    // Skid stage is only ever occupied behind a full output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a beat while output stage is empty");

    // Skid stage fills only when the output beat was stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid stage loaded without an output stall");

    // A not-found beat carries a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |-> (out_reg.address == '0))
        else $error("not-found result with non-zero address");

    // Region end clears start flags, the position and the match mark
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && region_end) |=> (flags_reg == '0 && !matched_reg
                                     && position_reg == '0))
        else $error("scan state not cleared after region end");
`endif

endmodule

[bench/tb_masked_byte_pattern_scan_top.sv]
`timescale 1ns / 100ps
// Testbench for masked_byte_pattern_scan_top: directed and random byte regions
// checked against a shadow scan kept here. Depends on mbps_pkg and the top level.
module tb_masked_byte_pattern_scan_top;

    import mbps_pkg::*;

    localparam int unsigned PATTERN_MAX   = 16;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 4;

    // Block ports
    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [7:0]        data_byte  = 8'd0;
    logic              region_end = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              match_found;
    logic [DATA_W-1:0] match_address;
    logic              cfg_write  = 1'b0;
    cfg_idx_t          cfg_index  = CFG_PATTERN_LOW;
    logic [DATA_W-1:0] cfg_data   = '0;

    // Shadow copy of the registers
    logic [63:0]       pat_lo   = '0;
    logic [63:0]       pat_hi   = '0;
    logic [15:0]       care_s   = CARE_MASK_RST;
    logic [LEN_W-1:0]  plen_s   = PATTERN_LEN_RST;
    logic [15:0]       stride_s = SCAN_STRIDE_RST;
    logic [63:0]       base_s   = '0;

    // Shadow copy of the scan state; window entry 0 is the newest byte
    logic [127:0]      win_bits    = '0;
    logic [15:0]       start_flags = '0;
    logic [15:0]       phase_s     = '0;
    logic [POS_W-1:0]  pos_s       = '0;
    logic              matched_s   = 1'b0;

    result_t           reports_due[$];
    result_t           due;
    logic [7:0]        region_buf[$];

    int unsigned       bytes_sent       = 0;
    int unsigned       regions_seen     = 0;
    int unsigned       reports_checked  = 0;
    int unsigned       matches_checked  = 0;
    int unsigned       settings_written = 0;
    int                fail_count       = 0;

    bit                tx_idle = 1'b1;
    bit                rx_idle = 1'b1;
    int unsigned       hold_token = 0;
    int unsigned       hold_seen  = 0;
    int unsigned       hold_left  = 0;
    int unsigned       stall_left = 0;

    masked_byte_pattern_scan_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .region_end    (region_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .match_found   (match_found),
        .match_address (match_address),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly short, now and then long
    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pattern_span();
        if (plen_s == 5'd0)
            return 1;
        if (plen_s > 5'(PATTERN_MAX))
            return PATTERN_MAX;
        return plen_s;
    endfunction

    // Advance the shadow scan by one accepted byte and queue any report it causes
    task automatic advance_shadow_scan(input logic [7:0] d, input logic e);
        int unsigned span;
        int unsigned strd;
        int unsigned j;
        logic [31:0] offset;
        logic [31:0] nxt;
        logic [127:0] pat;
        logic hit;
        result_t rep;
        span = pattern_span();
        strd = (stride_s == 16'd0) ? 1 : stride_s;
        offset = pos_s;
        pat = {pat_hi, pat_lo};
        win_bits = {win_bits[119:0], d};
        start_flags = {start_flags[14:0], phase_s == 16'd0};
        nxt = {16'd0, phase_s} + 32'd1;
        phase_s = (nxt >= strd) ? 16'd0 : nxt[15:0];
        pos_s = offset + 32'd1;
        if (!matched_s && start_flags[span - 1])
        begin
            hit = 1'b1;
            for (j = 0; j < span; j++)
            begin
                if (care_s[j] && pat[8 * j +: 8] != win_bits[8 * (span - 1 - j) +: 8])
                    hit = 1'b0;
            end
            if (hit)
            begin
                matched_s = 1'b1;
                rep.found = 1'b1;
                rep.address = base_s + {32'd0, offset - 32'(span - 1)};
                reports_due = {reports_due, rep};
            end
        end
        if (e)
        begin
            if (!matched_s)
            begin
                rep.found = 1'b0;
                rep.address = '0;
                reports_due = {reports_due, rep};
            end
            win_bits = '0;
            start_flags = '0;
            phase_s = '0;
            pos_s = '0;
            matched_s = 1'b0;
            regions_seen++;
        end
    endtask

    // Offer one beat, hold it until taken, then maybe leave a gap
    task automatic send_byte(input logic [7:0] d, input logic e);
        int unsigned gap;
        in_valid <= 1'b1;
        data_byte <= d;
        region_end <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_shadow_scan(d, e);
        bytes_sent++;
        gap = 0;
        if (tx_idle && $urandom_range(0, 3) == 0)
            gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every report is in and the block has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_PATTERN_LOW:  pat_lo = value;
            CFG_PATTERN_HIGH: pat_hi = value;
            CFG_CARE_MASK:    care_s = value[15:0];
            CFG_PATTERN_LEN:  plen_s = value[LEN_W-1:0];
            CFG_SCAN_STRIDE:  stride_s = value[15:0];
            CFG_REGION_BASE:  base_s = value;
            default: ;
        endcase
    endtask

    // Wait for idle, then write every register
    task automatic reconfigure(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [15:0] care, input logic [4:0] len,
                               input logic [15:0] strd, input logic [63:0] base);
        wait_idle();
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_CARE_MASK, {48'd0, care});
        write_reg(CFG_PATTERN_LEN, {59'd0, len});
        write_reg(CFG_SCAN_STRIDE, {48'd0, strd});
        write_reg(CFG_REGION_BASE, base);
        cfg_write <= 1'b0;
        settings_written++;
    endtask

    // Register values straight after reset: one byte that matches on the last byte
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
    endtask

    // Length above the maximum saturates, zero stride acts as one, end bytes wildcard
    task automatic test_length_and_stride_limits();
        logic [127:0] pat;
        logic [7:0] b;
        int unsigned j;
        reconfigure(64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988, 16'h7FFE,
                    5'd31, 16'd0, 64'h8000_0000_0000_0000);
        pat = {pat_hi, pat_lo};
        for (j = 0; j < PATTERN_MAX; j++)
        begin
            b = pat[8 * j +: 8];
            if (j == 0 || j == PATTERN_MAX - 1)
                b = ~b;
            send_byte(b, j == PATTERN_MAX - 1);
        end
    endtask

    // Region shorter than the pattern, then a wildcard match whose address wraps
    task automatic test_short_region_and_wrap();
        reconfigure(64'h0000_0000_EFBE_ADDE, 64'd0, 16'hFFFB, 5'd4, 16'd1,
                    64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'hDE, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hEF, 1'b1);
    endtask

    // Misaligned match skipped, aligned one taken, silent region end afterwards
    task automatic test_stride_and_late_end();
        reconfigure(64'h0000_0000_0000_AAAA, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 5'd2,
                    16'd2, 64'h0000_0000_0000_1000);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // Stride shrinks to the running phase in mid region; zero length acts as one
    task automatic test_mid_region_write();
        reconfigure(64'h0000_0000_0000_005A, 64'd0, 16'hFFFF, 5'd0, 16'd3,
                    64'h0000_0000_0000_2000);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        reconfigure(64'h0000_0000_0000_005A, 64'd0, 16'hFFFF, 5'd0, 16'd2,
                    64'h0000_0000_0000_2000);
        send_byte(8'h44, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    // Long receiver hold-off with a steady sender, then a full drain
    task automatic test_backpressure();
        int unsigned j;
        reconfigure({56'd0, 8'($urandom_range(0, 255))}, 64'd0, 16'hFFFF, 5'd1, 16'd1,
                    {$urandom, $urandom});
        tx_idle = 1'b0;
        hold_token++;
        for (j = 0; j < 24; j++)
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_idle();
        hold_token++;
        for (j = 0; j < 16; j++)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        wait_idle();
        tx_idle = 1'b1;
    endtask

    // Random settings; regions mostly carry a planted pattern at an aligned offset
    task automatic test_random_regions(input int unsigned target);
        int unsigned first;
        int unsigned phase_end;
        int unsigned r;
        int unsigned span;
        int unsigned strd;
        int unsigned rlen;
        int unsigned s;
        int unsigned j;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] base;
        logic [15:0] care;
        logic [15:0] stride;
        logic [4:0] len;
        logic [127:0] pat;
        first = bytes_sent;
        while (bytes_sent - first < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = 5'($urandom_range(1, 4));
            else if (r < 85)
                len = 5'($urandom_range(5, 15));
            else if (r < 95)
                len = 5'(PATTERN_MAX);
            else
                len = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(17, 31));
            r = $urandom_range(0, 99);
            if (r < 55)
                stride = 16'd1;
            else if (r < 80)
                stride = 16'($urandom_range(2, 5));
            else if (r < 90)
                stride = 16'($urandom_range(6, 40));
            else if (r < 95)
                stride = 16'hFFFF;
            else
                stride = 16'd0;
            r = $urandom_range(0, 99);
            care = (r < 50) ? 16'hFFFF : (r < 55) ? 16'h0000 : 16'($urandom);
            r = $urandom_range(0, 99);
            lo = (r < 10) ? '0 : (r < 20) ? '1 : {$urandom, $urandom};
            hi = (r < 10) ? '0 : (r < 20) ? '1 : {$urandom, $urandom};
            r = $urandom_range(0, 99);
            base = (r < 10) ? '0 : (r < 20) ? '1 : {$urandom, $urandom};
            reconfigure(lo, hi, care, len, stride, base);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            span = pattern_span();
            strd = (stride_s == 16'd0) ? 1 : stride_s;
            pat = {pat_hi, pat_lo};
            phase_end = bytes_sent + $urandom_range(80, 160);
            if (phase_end > first + target)
                phase_end = first + target;
            while (bytes_sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    rlen = $urandom_range(1, span + 3 * ((strd > 8) ? 8 : strd) + 8);
                else if (r < 97)
                    rlen = $urandom_range(20, 80);
                else
                    rlen = $urandom_range(150, 400);
                region_buf.delete();
                for (j = 0; j < rlen; j++)
                    region_buf = {region_buf, 8'($urandom_range(0, 255))};
                // plant the pattern: aligned most of the time, off the stride now and then
                r = $urandom_range(0, 99);
                if (r < 85 && rlen >= span)
                begin
                    s = $urandom_range(0, (rlen - span) / strd) * strd;
                    if (r >= 70 && strd > 1)
                        s = s + $urandom_range(1, strd - 1);
                    if (s + span > rlen)
                        s = 0;
                    for (j = 0; j < span; j++)
                    begin
                        if (care_s[j])
                            region_buf[s + j] = pat[8 * j +: 8];
                    end
                end
                for (j = 0; j < rlen; j++)
                    send_byte(region_buf[j], j == rlen - 1);
                if ($urandom_range(0, 19) == 0)
                    wait_idle();
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Result side: check each taken beat, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (reports_due.size() == 0)
            begin
                $error("unexpected report: match_found %0d, match_address %h",
                       match_found, match_address);
                fail_count++;
            end
            else
            begin
                due = reports_due.pop_front();
                reports_checked++;
                if (due.found)
                    matches_checked++;
                if (match_found !== due.found)
                begin
                    $error("match_found: expected %0d, got %0d", due.found, match_found);
                    fail_count++;
                end
                if (match_address !== due.address)
                begin
                    $error("match_address: expected %h, got %h", due.address, match_address);
                    fail_count++;
                end
            end
        end
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (rx_idle && $urandom_range(0, 5) == 0)
                stall_left = gap_length();
        end
    end

    // End the run when nothing has moved for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_length_and_stride_limits();
        test_short_region_and_wrap();
        test_stride_and_late_end();
        test_mid_region_write();
        test_backpressure();
        test_random_regions(1180);
        wait_idle();
        $display("summary: %0d bytes in %0d regions, %0d reports checked (%0d matches)",
                 bytes_sent, regions_seen, reports_checked, matches_checked);
        $display("summary: %0d register settings, lengths 0 to 31, strides 0 to 65535",
                 settings_written);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[masked_byte_pattern_scan_top.f]
src/mbps_pkg.sv
src/masked_byte_pattern_scan_top.sv
bench/tb_masked_byte_pattern_scan_top.sv
